@@ rtl/core/utf8_trigram_tokenizer_assert.svh @@
// ----------------------------------------------------------------------------
// utf8_trigram_tokenizer_assert.svh
// assertion macros for the trigram tokenizer, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef UTF8_TRIGRAM_TOKENIZER_ASSERT_SVH
`define UTF8_TRIGRAM_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked on every clock edge outside reset
`define UTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked on every clock edge, reset included
`define UTT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define UTT_ASSERT(label, prop, msg)
`define UTT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ rtl/core/utt_pkg.sv @@
// ----------------------------------------------------------------------------
// utt_pkg
// constants and code point helpers for the utf-8 trigram tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utt_pkg;

    localparam int OFFSET_BITS_DEF = 32;

    localparam logic [31:0] REPL_CODE    = 32'h0000_FFFD;
    localparam logic [31:0] SURR_BASE    = 32'h0000_D800;
    localparam logic [31:0] SURR_MASK    = 32'hFFFF_F800;
    localparam logic [31:0] NONCHAR_MASK = 32'hFFFF_FFFE;
    localparam logic [31:0] NONCHAR_BASE = 32'h0000_FFFE;
    localparam logic [31:0] SPACE_CODE   = 32'd32;
    localparam logic [7:0]  LEAD_MIN     = 8'hC0;
    localparam logic [7:0]  CONT_MASK    = 8'hC0;
    localparam logic [7:0]  CONT_TAG     = 8'h80;
    localparam logic [7:0]  PAYLOAD_MASK = 8'h3F;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
    } enc_t;

    // utf-8 re-encoding, byte 0 in bits 7:0, unused bytes zero
    function automatic enc_t encode(logic [31:0] c);
        enc_t e;
        e = '0;
        if (c < 32'h80) begin
            e.len   = 3'd1;
            e.bytes = c;
        end else if (c < 32'h800) begin
            e.len   = 3'd2;
            e.bytes = {16'h0, 2'b10, c[5:0], 3'b110, c[10:6]};
        end else if (c < 32'h10000) begin
            e.len   = 3'd3;
            e.bytes = {8'h0, 2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
        end else begin
            e.len   = 3'd4;
            e.bytes = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12], 5'b11110, c[20:18]};
        end
        return e;
    endfunction

    // payload bits of a lead byte
    function automatic logic [31:0] lead_bits(logic [7:0] b);
        logic [31:0] r;
        if (b < 8'hE0)      r = {27'h0, b[4:0]};
        else if (b < 8'hF0) r = {28'h0, b[3:0]};
        else if (b < 8'hF8) r = {29'h0, b[2:0]};
        else if (b < 8'hFC) r = {30'h0, b[1:0]};
        else if (b < 8'hFE) r = {31'h0, b[0]};
        else                r = 32'h0;
        return r;
    endfunction

    // overlong codes below 0x80, surrogates and U+FFFE, U+FFFF become the replacement char
    function automatic logic [31:0] fix_code(logic [31:0] c);
        logic bad;
        bad = (c < 32'h80) || ((c & SURR_MASK) == SURR_BASE) ||
              ((c & NONCHAR_MASK) == NONCHAR_BASE);
        return bad ? REPL_CODE : c;
    endfunction

endpackage

@@ rtl/core/utf8_trigram_tokenizer.sv @@
// ----------------------------------------------------------------------------
// utf8_trigram_tokenizer
// path: a byte is held in the input register until the result slots are free,
//   then it is decoded into the slot registers that drive m_*
// throughput: one byte per cycle while m_tready is high and bytes give at most
//   one token each; a byte with more holds the single result port until its last token leaves
// reset: aresetn low clears window count, pending char, offset and stop flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_trigram_tokenizer_assert.svh"

module utf8_trigram_tokenizer
    import utt_pkg::*;
#(
    parameter int  OFFSET_BITS = OFFSET_BITS_DEF,
    localparam int TOK_BITS    = 64 + 32 + 4 + 2 * OFFSET_BITS,
    localparam int M_TDATA_W   = ((TOK_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // byte stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    input  logic                  s_tlast,   // last byte of the text
    // token stream out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // token_lo, token_hi, token_length,
                                             // start_offset, end_offset, zero pad
    output logic                  m_tlast    // run_last
);

    typedef logic [OFFSET_BITS-1:0] off_t;

    // three character sliding window
    typedef struct packed {
        logic [2:0][31:0]          bytes;
        logic [2:0][2:0]           len;
        logic [2:0][OFFSET_BITS-1:0] start;
        logic [1:0]                count;
        logic                      mid;
    } win_t;

    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] hi;
        logic [3:0]  len;
        off_t        start_off;
        off_t        end_off;
    } tok_t;

    // one character pushed into the window, with the token it may cause
    typedef struct packed {
        win_t w;
        logic emit;
        win_t w_emit;
        off_t end_off;
    } take_t;

    // saturating byte counter step
    function automatic off_t sat_inc(off_t p);
        return (&p) ? p : p + off_t'(1);
    endfunction

    // pack the window characters into one token
    function automatic tok_t make_tok(win_t w, off_t end_off);
        tok_t        t;
        logic [95:0] buf_v;
        logic [3:0]  l0;
        logic [3:0]  l1;
        logic [3:0]  l2;
        l0    = (w.count != 2'd0) ? {1'b0, w.len[0]} : 4'd0;
        l1    = (w.count >= 2'd2) ? {1'b0, w.len[1]} : 4'd0;
        l2    = (w.count == 2'd3) ? {1'b0, w.len[2]} : 4'd0;
        buf_v = (w.count != 2'd0) ? 96'(w.bytes[0]) : 96'h0;
        if (w.count >= 2'd2) buf_v = buf_v | (96'(w.bytes[1]) << {l0, 3'b000});
        if (w.count == 2'd3) buf_v = buf_v | (96'(w.bytes[2]) << {l0 + l1, 3'b000});
        t.lo        = buf_v[63:0];
        t.hi        = buf_v[95:64];
        t.len       = l0 + l1 + l2;
        t.start_off = w.start[0];
        t.end_off   = end_off;
        return t;
    endfunction

    // a full window emits and slides first; a space closes the word
    function automatic take_t take_char(win_t w_in, logic [31:0] code, off_t start);
        take_t r;
        win_t  w;
        enc_t  e;
        w         = w_in;
        r.emit    = 1'b0;
        r.w_emit  = w_in;
        r.end_off = start;
        if (w.count == 2'd3) begin
            r.emit     = 1'b1;
            r.w_emit   = w;
            w.bytes[0] = w.bytes[1];
            w.len[0]   = w.len[1];
            w.start[0] = w.start[1];
            w.bytes[1] = w.bytes[2];
            w.len[1]   = w.len[2];
            w.start[1] = w.start[2];
            w.count    = 2'd2;
            w.mid      = 1'b1;
        end
        if (code == SPACE_CODE) begin
            // a short word that never filled the window goes out whole
            if (!w.mid && w.count != 2'd0) begin
                r.emit   = 1'b1;
                r.w_emit = w;
            end
            w.mid   = 1'b0;
            w.count = 2'd0;
        end else begin
            e                  = encode(code);
            w.bytes[w.count]   = e.bytes;
            w.len[w.count]     = e.len;
            w.start[w.count]   = start;
            w.count            = w.count + 2'd1;
        end
        r.w = w;
        return r;
    endfunction

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // tokenizer state
    win_t        win_reg,       win_next;
    logic [31:0] pend_code_reg, pend_code_next;
    logic        pend_valid_reg, pend_valid_next;
    off_t        pend_start_reg, pend_start_next;
    off_t        byte_pos_reg,  byte_pos_next;
    logic        stopped_reg,   stopped_next;

    // result slots for the tokens of one byte
    tok_t       slot_reg [3];
    tok_t       slot_next [3];
    logic [1:0] res_cnt_reg, res_cnt_next;
    logic [1:0] res_idx_reg;

    logic slot_free;
    logic adv;
    tok_t cur_tok;

    // output side: slots hold tokens until the last one is taken
    assign m_tvalid  = res_idx_reg < res_cnt_reg;
    assign m_tlast   = res_idx_reg == (res_cnt_reg - 2'd1);
    assign cur_tok   = slot_reg[res_idx_reg];
    assign m_tdata   = M_TDATA_W'({cur_tok.end_off, cur_tok.start_off, cur_tok.len,
                                   cur_tok.hi, cur_tok.lo});

    // the slots take a new byte's tokens once the last waiting one leaves
    assign slot_free = !m_tvalid || (m_tlast && m_tready);
    assign adv       = in_valid_reg && slot_free;
    assign s_tready  = !in_valid_reg || adv;

    // one byte of decode and window update
    always_comb begin
        win_t        w;
        take_t       tr;
        logic [31:0] pc;
        logic        pv;
        off_t        ps;
        off_t        pos;
        logic        st;
        logic [1:0]  n;
        logic [7:0]  b;

        w   = win_reg;
        pc  = pend_code_reg;
        pv  = pend_valid_reg;
        ps  = pend_start_reg;
        pos = byte_pos_reg;
        st  = stopped_reg;
        n   = 2'd0;
        b   = in_byte_reg;
        tr  = '0;
        for (int i = 0; i < 3; i++) slot_next[i] = '0;

        if (!st) begin
            if (pv && ((b & CONT_MASK) == CONT_TAG)) begin
                // continuation byte extends the pending char
                pc = (pc << 6) + {24'h0, b & PAYLOAD_MASK};
            end else begin
                if (pv) begin
                    tr = take_char(w, fix_code(pc), ps);
                    w  = tr.w;
                    if (tr.emit) begin
                        slot_next[n] = make_tok(tr.w_emit, tr.end_off);
                        n = n + 2'd1;
                    end
                    pv = 1'b0;
                    pc = 32'h0;
                end
                if (b >= LEAD_MIN) begin
                    // start offset of a lead byte is the current position
                    pc = lead_bits(b);
                    pv = 1'b1;
                    ps = pos;
                end else if (b == 8'h00) begin
                    // zero byte: flush and stop until the end of the text
                    if (w.count != 2'd0) begin
                        slot_next[n] = make_tok(w, sat_inc(pos));
                        n = n + 2'd1;
                    end
                    w.count = 2'd0;
                    st      = 1'b1;
                end else begin
                    tr = take_char(w, {24'h0, b}, pos);
                    w  = tr.w;
                    if (tr.emit) begin
                        slot_next[n] = make_tok(tr.w_emit, tr.end_off);
                        n = n + 2'd1;
                    end
                end
            end
            pos = sat_inc(pos);
            // end of text flushes the pending char and the window
            if (in_last_reg && !st) begin
                if (pv) begin
                    tr = take_char(w, fix_code(pc), ps);
                    w  = tr.w;
                    if (tr.emit) begin
                        slot_next[n] = make_tok(tr.w_emit, tr.end_off);
                        n = n + 2'd1;
                    end
                    pv = 1'b0;
                    pc = 32'h0;
                end
                if (w.count != 2'd0) begin
                    slot_next[n] = make_tok(w, pos);
                    n = n + 2'd1;
                end
            end
        end

        // a new text starts from reset state
        if (in_last_reg) begin
            w.count = 2'd0;
            w.mid   = 1'b0;
            pc      = 32'h0;
            pv      = 1'b0;
            ps      = '0;
            pos     = '0;
            st      = 1'b0;
        end

        win_next        = w;
        pend_code_next  = pc;
        pend_valid_next = pv;
        pend_start_next = ps;
        byte_pos_next   = pos;
        stopped_next    = st;
        res_cnt_next    = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            win_reg.count  <= 2'd0;
            win_reg.mid    <= 1'b0;
            pend_code_reg  <= 32'h0;
            pend_valid_reg <= 1'b0;
            pend_start_reg <= '0;
            byte_pos_reg   <= '0;
            stopped_reg    <= 1'b0;
            res_cnt_reg    <= 2'd0;
            res_idx_reg    <= 2'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                win_reg        <= win_next;
                pend_code_reg  <= pend_code_next;
                pend_valid_reg <= pend_valid_next;
                pend_start_reg <= pend_start_next;
                byte_pos_reg   <= byte_pos_next;
                stopped_reg    <= stopped_next;
                res_cnt_reg    <= res_cnt_next;
                res_idx_reg    <= 2'd0;
            end else if (m_tvalid && m_tready) begin
                res_idx_reg <= res_idx_reg + 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (adv) begin
            for (int i = 0; i < 3; i++) slot_reg[i] <= slot_next[i];
        end
    end

    // assertions
    `UTT_ASSERT(a_idx_in_range, (res_idx_reg <= res_cnt_reg), "token index past token count")
    `UTT_ASSERT(a_hold_byte, (in_valid_reg && !adv |=> in_valid_reg && $stable(in_byte_reg)), "waiting byte lost or changed")
    `UTT_ASSERT(a_text_end, (adv && in_last_reg |=> byte_pos_reg == '0 && win_reg.count == 2'd0 && !stopped_reg && !pend_valid_reg), "state not cleared after last byte")
    `UTT_ASSERT_ALWAYS(a_stop_no_pend, (stopped_reg |-> !pend_valid_reg), "pending char while stopped")

endmodule
